@@ hdl/feature_min_max_scaler_defines.svh @@
// Assertion macros shared by the feature scaler modules.
`ifndef FEATURE_MIN_MAX_SCALER_DEFINES_SVH
`define FEATURE_MIN_MAX_SCALER_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define FMMS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define FMMS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/fmms_pkg.sv @@
// Package with the types and constants of the feature min-max scaler.
`default_nettype none

package fmms_pkg;

    localparam int FMMS_NUM_FEATURES = 64;
    localparam int IDX_BITS = 6;
    localparam int DATA_BITS = 32;
    localparam int OUT_BITS = 18;
    localparam int QUOT_BITS = 17;
    localparam int QUEUE_DEPTH = 2;
    localparam int IDX_CMP_BITS = 11;

    localparam logic [1:0] FUNC_LOAD = 2'd0;
    localparam logic [1:0] FUNC_OBSERVE = 2'd1;
    localparam logic [1:0] FUNC_SCALE = 2'd2;

    localparam logic signed [DATA_BITS-1:0] MIN_RESET = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_BITS-1:0] MAX_RESET = 32'sh8000_0000;
    localparam logic signed [OUT_BITS-1:0] ONE_Q16 = 18'sd65536;
    localparam logic signed [OUT_BITS-1:0] MINUS_ONE_Q16 = -18'sd65536;

    typedef enum logic [1:0] {
        OP_LOAD,
        OP_OBSERVE,
        OP_SCALE
    } op_code_t;

    typedef struct packed {
        op_code_t                     op;
        logic [IDX_BITS-1:0]          idx;
        logic signed [DATA_BITS-1:0]  value;
        logic signed [DATA_BITS-1:0]  lo;
        logic signed [DATA_BITS-1:0]  hi;
    } item_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EVAL,
        ST_DIV,
        ST_OUT
    } back_state_t;

endpackage

`default_nettype wire

@@ hdl/fmms_front.sv @@
// Front end: accepts stream transactions, decodes the operation and drops unusable ones.
`default_nettype none

module fmms_front
    import fmms_pkg::*;
#(
    parameter int NUM_FEATURES = FMMS_NUM_FEATURES
)
(
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [103:0] s_axis_tdata,
    input  wire logic [1:0]   s_axis_tuser,
    input  wire logic         table_ready,
    input  wire logic         queue_full,
    output logic              push,
    output item_t             push_item
);

    logic [IDX_BITS-1:0]     idx;
    logic [IDX_CMP_BITS-1:0] idx_ext;
    logic                    in_range;
    logic                    known_op;
    logic                    accept;

    assign idx      = s_axis_tdata[5:0];
    assign idx_ext  = IDX_CMP_BITS'(idx);
    assign in_range = idx_ext < IDX_CMP_BITS'(NUM_FEATURES);
    assign s_axis_tready = table_ready && !queue_full;
    assign accept   = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        push_item.idx   = idx;
        push_item.value = s_axis_tdata[37:6];
        push_item.lo    = s_axis_tdata[69:38];
        push_item.hi    = s_axis_tdata[101:70];
        known_op        = 1'b1;
        unique case (s_axis_tuser)
            FUNC_LOAD:    push_item.op = OP_LOAD;
            FUNC_OBSERVE: push_item.op = OP_OBSERVE;
            FUNC_SCALE:   push_item.op = OP_SCALE;
            default:
            begin
                push_item.op = OP_LOAD;
                known_op     = 1'b0;
            end
        endcase
        // Unknown codes and indexes past the table are consumed without effect.
        push = accept && known_op && in_range;
    end

endmodule

`default_nettype wire

@@ hdl/fmms_queue.sv @@
// Short queue of decoded items between the front end and the back end.
`default_nettype none

module fmms_queue
    import fmms_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    input  wire item_t push_item,
    input  wire logic  pop,
    output item_t      head,
    output logic       full,
    output logic       empty
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    item_t            slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wptr_reg;
    logic [PTR_W-1:0] wptr_next;
    logic [PTR_W-1:0] rptr_reg;
    logic [PTR_W-1:0] rptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full  = count_reg == CNT_W'(QUEUE_DEPTH);
    assign empty = count_reg == '0;
    assign head  = slot_reg[rptr_reg];

    always_comb
    begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (push)
        begin
            wptr_next = (wptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
        end
        if (pop)
        begin
            rptr_next = (rptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wptr_reg] <= push_item;
        end
    end

`include "feature_min_max_scaler_defines.svh"

    `FMMS_ASSERT_NOW(a_no_push_when_full, full, !push, "queue written while full")
    `FMMS_ASSERT_NOW(a_no_pop_when_empty, empty, !pop, "queue read while empty")
    `FMMS_ASSERT_NEXT(a_count_follows_push, push && !pop, !empty, "queue lost a pushed item")

endmodule

`default_nettype wire

@@ hdl/fmms_div.sv @@
// Radix-2 restoring divider giving the scaled ratio one quotient bit per cycle.
`default_nettype none

module fmms_div
    import fmms_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic [DATA_BITS-1:0] num,
    input  wire logic [DATA_BITS-1:0] den,
    output logic                      busy,
    output logic                      done,
    output logic [QUOT_BITS-1:0]      quot
);

    localparam int CNT_W = $clog2(QUOT_BITS);

    logic                 busy_reg;
    logic                 done_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [DATA_BITS-1:0] rem_reg;
    logic [DATA_BITS-1:0] den_reg;
    logic [QUOT_BITS-1:0] quot_reg;
    logic [DATA_BITS:0]   shifted;
    logic [DATA_BITS:0]   diff;
    logic                 fits;
    logic                 last;

    // The remainder always stays below the divisor, so the doubled value fits 33 bits.
    assign shifted = {rem_reg, 1'b0};
    assign diff    = shifted - {1'b0, den_reg};
    assign fits    = shifted >= {1'b0, den_reg};
    assign last    = cnt_reg == CNT_W'(QUOT_BITS - 1);

    assign busy = busy_reg;
    assign done = done_reg;
    assign quot = quot_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && last;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (last)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= num;
            den_reg  <= den;
            quot_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg  <= fits ? diff[DATA_BITS-1:0] : shifted[DATA_BITS-1:0];
            quot_reg <= {quot_reg[QUOT_BITS-2:0], fits};
        end
    end

endmodule

`default_nettype wire

@@ hdl/fmms_back.sv @@
// Back end: bounds memory, operation sequencer and the output register.
`default_nettype none

module fmms_back
    import fmms_pkg::*;
#(
    parameter int NUM_FEATURES = FMMS_NUM_FEATURES
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire item_t       head,
    input  wire logic        queue_empty,
    output logic             pop,
    output logic             table_ready,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata
);

    localparam int ADDR_W = (NUM_FEATURES > 1) ? $clog2(NUM_FEATURES) : 1;
    localparam int WORD_W = 2 * DATA_BITS;

    back_state_t                 state_reg;
    back_state_t                 state_next;
    logic [ADDR_W-1:0]           clr_reg;
    logic [ADDR_W-1:0]           clr_next;
    item_t                       cur_reg;
    item_t                       cur_next;
    logic signed [OUT_BITS-1:0]  res_reg;
    logic signed [OUT_BITS-1:0]  res_next;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic [IDX_BITS-1:0]         out_idx_reg;
    logic signed [OUT_BITS-1:0]  out_val_reg;
    logic                        out_load;
    logic                        res_in_range;

    logic [WORD_W-1:0]           mem [NUM_FEATURES];
    logic [WORD_W-1:0]           rd_data_reg;
    logic [ADDR_W-1:0]           rd_addr;
    logic [ADDR_W-1:0]           wr_addr;
    logic [WORD_W-1:0]           wr_data;
    logic                        wr_en;

    logic signed [DATA_BITS-1:0] mn;
    logic signed [DATA_BITS-1:0] mx;
    logic                        at_low;
    logic                        at_high;
    logic [DATA_BITS:0]          num_wide;
    logic [DATA_BITS:0]          den_wide;
    logic                        div_start;
    logic                        div_busy;
    logic                        div_done;
    logic [QUOT_BITS-1:0]        div_quot;

    assign mn = rd_data_reg[DATA_BITS-1:0];
    assign mx = rd_data_reg[WORD_W-1:DATA_BITS];

    assign at_low  = cur_reg.value <= mn;
    assign at_high = cur_reg.value >= mx;
    assign num_wide = {cur_reg.value[DATA_BITS-1], cur_reg.value} - {mn[DATA_BITS-1], mn};
    assign den_wide = {mx[DATA_BITS-1], mx} - {mn[DATA_BITS-1], mn};

    assign rd_addr = ADDR_W'(IDX_CMP_BITS'(head.idx));
    assign wr_addr = (state_reg == ST_CLEAR) ? clr_reg : ADDR_W'(IDX_CMP_BITS'(cur_reg.idx));

    assign table_ready   = state_reg != ST_CLEAR;
    assign out_load      = (state_reg == ST_OUT) && (!out_valid_reg || m_axis_tready);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_val_reg, out_idx_reg};
    assign res_in_range  = (res_reg >= MINUS_ONE_Q16) && (res_reg <= ONE_Q16);

    fmms_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num_wide[DATA_BITS-1:0]),
        .den   (den_wide[DATA_BITS-1:0]),
        .busy  (div_busy),
        .done  (div_done),
        .quot  (div_quot)
    );

    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        cur_next   = cur_reg;
        res_next   = res_reg;
        pop        = 1'b0;
        wr_en      = 1'b0;
        wr_data    = {cur_reg.hi, cur_reg.lo};
        div_start  = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_data = {MAX_RESET, MIN_RESET};
                clr_next = clr_reg + 1'b1;
                if (clr_reg == ADDR_W'(NUM_FEATURES - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (!queue_empty)
                begin
                    pop        = 1'b1;
                    cur_next   = head;
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                unique case (cur_reg.op)
                    OP_LOAD:
                    begin
                        wr_en      = 1'b1;
                        state_next = ST_IDLE;
                    end
                    OP_OBSERVE:
                    begin
                        wr_en      = 1'b1;
                        wr_data    = {at_high ? cur_reg.value : mx,
                                      at_low ? cur_reg.value : mn};
                        // Equal values leave the bound as it is either way.
                        state_next = ST_IDLE;
                    end
                    OP_SCALE:
                    begin
                        priority if (at_low)
                        begin
                            res_next   = MINUS_ONE_Q16;
                            state_next = ST_OUT;
                        end
                        else if (at_high)
                        begin
                            res_next   = ONE_Q16;
                            state_next = ST_OUT;
                        end
                        else
                        begin
                            div_start  = 1'b1;
                            state_next = ST_DIV;
                        end
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    res_next   = OUT_BITS'({1'b0, div_quot}) + MINUS_ONE_Q16;
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        out_valid_next = out_load || (out_valid_reg && !m_axis_tready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        res_reg <= res_next;
        if (out_load)
        begin
            out_idx_reg <= cur_reg.idx;
            out_val_reg <= res_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

`include "feature_min_max_scaler_defines.svh"

    `FMMS_ASSERT_NOW(a_div_only_in_div, div_busy, state_reg == ST_DIV, "divider busy early")
    `FMMS_ASSERT_NEXT(a_div_done_to_out, state_reg == ST_DIV && div_done, state_reg == ST_OUT, "quotient lost")
    `FMMS_ASSERT_NOW(a_result_in_range, out_load, res_in_range, "scaled value outside range")
    `FMMS_ASSERT_NOW(a_no_pop_while_clearing, state_reg == ST_CLEAR, !pop, "pop during clearing")

endmodule

`default_nettype wire

@@ hdl/feature_min_max_scaler.sv @@
// Top level of the feature min-max scaler: front end, item queue and back end.
//
// The block keeps a minimum and a maximum in signed Q16.16 for each of NUM_FEATURES
// features. Each input transaction carries an operation in s_axis_tuser: load writes
// both bounds of one entry, observe widens the entry's bounds with a sample, and scale
// maps a value into -1.0 .. +1.0 against the entry and sends one output transaction
// with the feature number and the scaled value. Load and observe send nothing; an
// unused operation code or a feature number past the table is consumed and ignored.
// After reset the bounds memory is swept, one entry per cycle, to the empty range, and
// s_axis_tready stays low until the sweep is done.
// The front end decodes items into a two-entry queue; the back end works them one at
// a time. Load and observe are taken from the queue in the idle state and written to
// the bounds memory in the evaluate state. A scale whose value lies at or past a bound
// goes from evaluation straight to the output state; any other scale runs the radix-2
// divider, one quotient bit per cycle, and enters the output state when it is done.
// The result waits in the output register while m_axis_tready is low; meanwhile the
// queue keeps taking input until it fills, and the back end stalls only when the
// next result finds the output register still occupied.
`default_nettype none

module feature_min_max_scaler
    import fmms_pkg::*;
#(
    parameter int NUM_FEATURES = FMMS_NUM_FEATURES
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // feature_index [5:0], feature_value [37:6], low_bound [69:38],
    // high_bound [101:70], zero fill [103:102]
    input  wire logic [103:0] s_axis_tdata,
    // func [1:0]
    input  wire logic [1:0]   s_axis_tuser,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // out_index [5:0], scaled_value [23:6]
    output logic [23:0]       m_axis_tdata
);

    logic  table_ready;
    logic  queue_full;
    logic  queue_empty;
    logic  push;
    logic  pop;
    item_t push_item;
    item_t head;

    fmms_front #(
        .NUM_FEATURES (NUM_FEATURES)
    ) u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .table_ready   (table_ready),
        .queue_full    (queue_full),
        .push          (push),
        .push_item     (push_item)
    );

    fmms_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head      (head),
        .full      (queue_full),
        .empty     (queue_empty)
    );

    fmms_back #(
        .NUM_FEATURES (NUM_FEATURES)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .queue_empty   (queue_empty),
        .pop           (pop),
        .table_ready   (table_ready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

`default_nettype wire
